[design/tmap_pkg.sv]
// Shared types and constants for the scrolling tilemap copy generator.
package tmap_pkg;

  localparam int DEF_WINDOW_TILES    = 32;
  localparam int DEF_MAX_MAP_ENTRIES = 1048576;

  localparam int OP_W        = 2;
  localparam int PIX_W       = 13;
  localparam int TILE_SHIFT  = 3;
  localparam int TILE_W      = 10;
  localparam int COORD_W     = 11;
  localparam int WIDTH_W     = 11;
  localparam int SIZE_W      = 21;
  localparam int SRC_W       = 20;
  localparam int DEST_W      = 10;
  localparam int SRC_FULL_W  = 22;
  localparam int LIMIT_W     = 25;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 21;
  localparam int RECIP_SHIFT = 16;

  localparam logic [WIDTH_W-1:0] MAP_WIDTH_RST = 11'd64;
  localparam logic [SIZE_W-1:0]  MAP_SIZE_RST  = 21'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_SEED = 2'd0,
    OP_MOVE = 2'd1,
    OP_FILL = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH = 1'b0,
    REG_MAP_SIZE  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic row;
    logic fix;
    logic emit;
    logic last;
  } tmap_cmd_t;

  typedef struct packed {
    logic col_need;
    logic row_need;
    logic out_free;
  } tmap_stat_t;

endpackage

[design/tmap_if.sv]
// Valid/ready channel interfaces for camera input and copy results.
interface tmap_in_if import tmap_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [PIX_W-1:0] cam_x_pixels;
  logic [PIX_W-1:0] cam_y_pixels;

  modport source(output valid, op, cam_x_pixels, cam_y_pixels, input ready);
  modport sink(input valid, op, cam_x_pixels, cam_y_pixels, output ready);
endinterface

interface tmap_out_if import tmap_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SRC_W-1:0]  src_index;
  logic [DEST_W-1:0] dest_index;
  logic              beyond_map;
  logic              last_copy;

  modport source(output valid, src_index, dest_index, beyond_map, last_copy, input ready);
  modport sink(input valid, src_index, dest_index, beyond_map, last_copy, output ready);
endinterface

[design/scrolling_tilemap_copy_generator.sv]
// Top level of the scrolling tilemap copy generator.
//
//   port       dir   kind          carries
//   in_ch      in    valid/ready   op, cam_x_pixels, cam_y_pixels
//   out_ch     out   valid/ready   src_index, dest_index, beyond_map, last_copy
//   cfg_*      in    write only    map_width (index 0), map_size (index 1)
//
// One item at a time. Seed, no-change move and unused op: accept, pick, back to idle.
// Each column or row segment: pick, multiply and mod setup steps, then WINDOW_TILES
// copies at one per cycle unless out_ch stalls; a diagonal move runs column, then row.
// Synchronous active-low reset; config returns to 64 / 4096, position to 0.
// A stalled out_ch holds the copy sequencer; the output register frees in_ch.
module scrolling_tilemap_copy_generator import tmap_pkg::*; #(
  parameter int WINDOW_TILES    = DEF_WINDOW_TILES,
  parameter int MAX_MAP_ENTRIES = DEF_MAX_MAP_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tmap_in_if.sink               in_ch,
  tmap_out_if.source            out_ch
);

  tmap_cmd_t  cmd;
  tmap_stat_t stat;

  tmap_ctrl #(
    .WINDOW_TILES(WINDOW_TILES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tmap_dp #(
    .WINDOW_TILES    (WINDOW_TILES),
    .MAX_MAP_ENTRIES (MAX_MAP_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_ch.op),
    .in_cam_x_pixels (in_ch.cam_x_pixels),
    .in_cam_y_pixels (in_ch.cam_y_pixels),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_src_index   (out_ch.src_index),
    .out_dest_index  (out_ch.dest_index),
    .out_beyond_map  (out_ch.beyond_map),
    .out_last_copy   (out_ch.last_copy)
  );

endmodule

[design/tmap_ctrl.sv]
// Sequencer: walks the column and row segments of one input, one copy per cycle while the output is free.
module tmap_ctrl import tmap_pkg::*; #(
  parameter int WINDOW_TILES = DEF_WINDOW_TILES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output tmap_cmd_t  cmd,
  input  tmap_stat_t stat
);

  localparam int              WIN_W    = $clog2(WINDOW_TILES);
  localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(WINDOW_TILES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_MUL,
    S_MOD,
    S_RUN
  } state_t;

  state_t           state_r, state_nxt;
  logic             seg_row_r, seg_row_nxt;
  logic [WIN_W-1:0] k_r, k_nxt;

  always_comb begin
    state_nxt   = state_r;
    seg_row_nxt = seg_row_r;
    k_nxt       = k_r;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept  = 1'b1;
          seg_row_nxt = 1'b0;
          state_nxt   = S_PICK;
        end
      end
      S_PICK: begin
        if (!seg_row_r && stat.col_need) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end else if (stat.row_need) begin
          cmd.load    = 1'b1;
          cmd.row     = 1'b1;
          seg_row_nxt = 1'b1;
          state_nxt   = S_MUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.fix   = 1'b1;
        k_nxt     = '0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = (k_r == WIN_LAST) && (seg_row_r || !stat.row_need);
          if (k_r == WIN_LAST) begin
            if (seg_row_r) begin
              state_nxt = S_IDLE;
            end else begin
              seg_row_nxt = 1'b1;
              state_nxt   = S_PICK;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      seg_row_r <= 1'b0;
      k_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      seg_row_r <= seg_row_nxt;
      k_r       <= k_nxt;
    end
  end

endmodule

[design/tmap_dp.sv]
// Datapath: config registers, tile position compare, index arithmetic, output register.
module tmap_dp import tmap_pkg::*; #(
  parameter int WINDOW_TILES    = DEF_WINDOW_TILES,
  parameter int MAX_MAP_ENTRIES = DEF_MAX_MAP_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [OP_W-1:0]       in_op,
  input  logic [PIX_W-1:0]      in_cam_x_pixels,
  input  logic [PIX_W-1:0]      in_cam_y_pixels,
  input  tmap_cmd_t             cmd,
  output tmap_stat_t            stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [SRC_W-1:0]      out_src_index,
  output logic [DEST_W-1:0]     out_dest_index,
  output logic                  out_beyond_map,
  output logic                  out_last_copy
);

  localparam int                 WIN_W     = $clog2(WINDOW_TILES);
  localparam logic [WIN_W-1:0]   WIN_LAST  = WIN_W'(WINDOW_TILES - 1);
  localparam logic [COORD_W-1:0] EDGE      = COORD_W'(WINDOW_TILES - 1);
  localparam int                 RECIP     = (1 << RECIP_SHIFT) / WINDOW_TILES;
  localparam int                 RECIP_W   = $clog2(RECIP + 1);
  localparam int                 QPROD_W   = COORD_W + RECIP_W;
  localparam int                 REM_W     = COORD_W + 1;
  localparam int                 DFULL_W   = 2 * WIN_W + DEST_W;
  localparam logic [LIMIT_W-1:0] MAX_LIMIT = LIMIT_W'(MAX_MAP_ENTRIES);

  logic [WIDTH_W-1:0]    map_width_r;
  logic [SIZE_W-1:0]     map_size_r;
  logic [TILE_W-1:0]     prev_x_r, prev_y_r;
  logic [TILE_W-1:0]     tx_r, ty_r;
  logic [COORD_W-1:0]    col_x_r, row_y_r;
  logic                  col_need_r, row_need_r;
  logic [COORD_W-1:0]    seg_x_r, seg_y_r;
  logic                  seg_row_r;
  logic [SRC_FULL_W-1:0] prod_r;
  logic [QPROD_W-1:0]    qx_r, qy_r;
  logic [SRC_FULL_W-1:0] acc_r;
  logic [WIN_W-1:0]      dx_r, dy_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [SRC_W-1:0]      src_r;
  logic [DEST_W-1:0]     dest_r;
  logic                  beyond_r, last_r;

  logic [TILE_W-1:0]     tx, ty;
  logic                  upd_prev, col_need, row_need;
  logic [COORD_W-1:0]    col_x, row_y;
  logic [REM_W-1:0]      rx_est, ry_est, rx, ry;
  logic [DFULL_W-1:0]    dest_full;
  logic                  beyond;

  assign tx = in_cam_x_pixels[PIX_W-1:TILE_SHIFT];
  assign ty = in_cam_y_pixels[PIX_W-1:TILE_SHIFT];

  always_comb begin
    upd_prev = 1'b0;
    col_need = 1'b0;
    row_need = 1'b0;
    row_y    = COORD_W'(ty);
    case (op_t'(in_op))
      OP_SEED: begin
        upd_prev = 1'b1;
      end
      OP_MOVE: begin
        upd_prev = 1'b1;
        col_need = (tx != prev_x_r);
        row_need = (ty != prev_y_r);
        if (ty > prev_y_r) begin
          row_y = COORD_W'(ty) + EDGE;
        end
      end
      OP_FILL: begin
        row_need = 1'b1;
      end
      default: begin
        upd_prev = 1'b0;
      end
    endcase
    col_x = (tx < prev_x_r) ? COORD_W'(tx) : COORD_W'(tx) + EDGE;
  end

  // coordinate mod window size: reciprocal estimate, then one correction
  always_comb begin
    rx_est = REM_W'(seg_x_r)
           - REM_W'(REM_W'(qx_r[QPROD_W-1:RECIP_SHIFT]) * REM_W'(WINDOW_TILES));
    ry_est = REM_W'(seg_y_r)
           - REM_W'(REM_W'(qy_r[QPROD_W-1:RECIP_SHIFT]) * REM_W'(WINDOW_TILES));
    rx = (rx_est >= REM_W'(WINDOW_TILES)) ? rx_est - REM_W'(WINDOW_TILES) : rx_est;
    ry = (ry_est >= REM_W'(WINDOW_TILES)) ? ry_est - REM_W'(WINDOW_TILES) : ry_est;
  end

  assign dest_full = DFULL_W'(DFULL_W'(dy_r) * DFULL_W'(WINDOW_TILES)) + DFULL_W'(dx_r);
  assign beyond    = (acc_r >= SRC_FULL_W'(map_size_r))
                  || (LIMIT_W'(acc_r) >= MAX_LIMIT)
                  || (|acc_r[SRC_FULL_W-1:SRC_W]);

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r <= MAP_WIDTH_RST;
      map_size_r  <= MAP_SIZE_RST;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAP_WIDTH: map_width_r <= cfg_wdata[WIDTH_W-1:0];
          REG_MAP_SIZE:  map_size_r  <= cfg_wdata[SIZE_W-1:0];
          default:       map_size_r  <= map_size_r;
        endcase
      end
      if (cmd.accept && upd_prev) begin
        prev_x_r <= tx;
        prev_y_r <= ty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tx_r       <= tx;
      ty_r       <= ty;
      col_x_r    <= col_x;
      row_y_r    <= row_y;
      col_need_r <= col_need;
      row_need_r <= row_need;
    end
    if (cmd.load) begin
      seg_x_r   <= cmd.row ? COORD_W'(tx_r) : col_x_r;
      seg_y_r   <= cmd.row ? row_y_r : COORD_W'(ty_r);
      seg_row_r <= cmd.row;
    end
    prod_r <= SRC_FULL_W'(seg_y_r) * SRC_FULL_W'(map_width_r);
    qx_r   <= QPROD_W'(seg_x_r) * QPROD_W'(RECIP);
    qy_r   <= QPROD_W'(seg_y_r) * QPROD_W'(RECIP);
    if (cmd.fix) begin
      acc_r <= prod_r + SRC_FULL_W'(seg_x_r);
      dx_r  <= rx[WIN_W-1:0];
      dy_r  <= ry[WIN_W-1:0];
    end else if (cmd.emit) begin
      if (seg_row_r) begin
        acc_r <= acc_r + SRC_FULL_W'(1);
        dx_r  <= (dx_r == WIN_LAST) ? '0 : dx_r + 1'b1;
      end else begin
        acc_r <= acc_r + SRC_FULL_W'(map_width_r);
        dy_r  <= (dy_r == WIN_LAST) ? '0 : dy_r + 1'b1;
      end
    end
    if (cmd.emit) begin
      src_r    <= acc_r[SRC_W-1:0];
      dest_r   <= dest_full[DEST_W-1:0];
      beyond_r <= beyond;
      last_r   <= cmd.last;
    end
  end

  assign stat.col_need = col_need_r;
  assign stat.row_need = row_need_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_src_index  = src_r;
  assign out_dest_index = dest_r;
  assign out_beyond_map = beyond_r;
  assign out_last_copy  = last_r;

endmodule
